// File: rtl/lfac_pkg.sv
// shared types and constants of the fully associative lru cache
package lfac_pkg;

   localparam int KEY_PORT_BITS   = 64;
   localparam int VALUE_PORT_BITS = 64;
   localparam int STAMP_BITS      = 32;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // latch request, advance use clock, clear search
      logic scan;    // step the entry scan
      logic finish;  // write the chosen entry and register the result
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic scan_last;  // last entry is being evaluated
   } dp_status_type;

endpackage

// File: rtl/lfac_ram.sv
// generic single write port ram with registered read
module lfac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/lfac_ctrl.sv
// controller state machine of the lru cache
module lfac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lfac_pkg::dp_status_type status,
   output lfac_pkg::ctl_cmd_type   cmd,
   output logic                   busy
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/lfac_dpath.sv
// datapath of the lru cache: entry store, scan and result registers
module lfac_dpath #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfac_pkg::ctl_cmd_type                 cmd,
   output lfac_pkg::dp_status_type               status,
   input  logic                                 req_operation,
   input  logic [lfac_pkg::KEY_PORT_BITS-1:0]   req_key,
   input  logic [lfac_pkg::VALUE_PORT_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [$clog2(ENTRIES)-1:0]           rsp_slot,
   output logic [lfac_pkg::VALUE_PORT_BITS-1:0] rsp_stored_value,
   output logic                                 rsp_evicted
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int SB     = lfac_pkg::STAMP_BITS;
   localparam int WORD_W = SB + VALUE_BITS + KEY_BITS;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

   // request and use clock
   logic                  op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [SB-1:0]         use_clock_ff;

   // scan
   logic [CNT_W-1:0]   cnt_ff;
   logic               eval_en_ff;
   logic [IDX_W-1:0]   eval_idx_ff;
   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic [WORD_W-1:0]  rd_data;
   logic [ENTRIES-1:0] valid_ff;

   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic [SB-1:0]         rd_stamp;

   // search results
   logic                  found_ff;
   logic [IDX_W-1:0]      found_idx_ff;
   logic [VALUE_BITS-1:0] found_value_ff;
   logic                  free_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic                  min_set_ff;
   logic [IDX_W-1:0]      min_idx_ff;
   logic [SB-1:0]         min_stamp_ff;

   logic                  match;
   logic [IDX_W-1:0]      target;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_data;

   // result registers
   logic                                 rsp_valid_ff;
   logic                                 rsp_hit_ff;
   logic [IDX_W-1:0]                     rsp_slot_ff;
   logic [lfac_pkg::VALUE_PORT_BITS-1:0] rsp_stored_value_ff;
   logic                                 rsp_evicted_ff;

   assign rd_addr  = (cnt_ff < LAST_CNT) ? cnt_ff[IDX_W-1:0] : '0;
   assign rd_key   = rd_data[KEY_BITS-1:0];
   assign rd_value = rd_data[KEY_BITS +: VALUE_BITS];
   assign rd_stamp = rd_data[KEY_BITS + VALUE_BITS +: SB];
   assign match    = eval_en_ff && rd_valid_ff && (rd_key == key_ff);
   assign target   = free_ff ? free_idx_ff : min_idx_ff;

   assign status.scan_last = (cnt_ff == LAST_CNT);

   lfac_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ENTRIES)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // write back: insert fills target, lookup hit restamps its entry
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = target;
      wr_data = {use_clock_ff, value_ff, key_ff};
      if (cmd.finish) begin
         if (op_ff == lfac_pkg::OP_INSERT) begin
            wr_en = 1'b1;
         end else if (found_ff) begin
            wr_en   = 1'b1;
            wr_addr = found_idx_ff;
            wr_data = {use_clock_ff, found_value_ff, key_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         use_clock_ff <= '0;
         eval_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && (use_clock_ff != '1)) begin
            use_clock_ff <= use_clock_ff + SB'(1);
         end
         if (cmd.finish && (op_ff == lfac_pkg::OP_INSERT)) begin
            valid_ff[target] <= 1'b1;
         end
         eval_en_ff   <= cmd.scan && (cnt_ff < LAST_CNT);
         rsp_valid_ff <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         key_ff     <= req_key[KEY_BITS-1:0];
         value_ff   <= req_value[VALUE_BITS-1:0];
         cnt_ff     <= '0;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         min_set_ff <= 1'b0;
      end else if (cmd.scan) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      eval_idx_ff <= rd_addr;
      rd_valid_ff <= valid_ff[rd_addr];

      if (eval_en_ff) begin
         if (match && !found_ff) begin
            found_ff       <= 1'b1;
            found_idx_ff   <= eval_idx_ff;
            found_value_ff <= rd_value;
         end
         if (!rd_valid_ff && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= eval_idx_ff;
         end
         // strict less keeps the lowest index on equal stamps
         if (rd_valid_ff && (!min_set_ff || (rd_stamp < min_stamp_ff))) begin
            min_set_ff   <= 1'b1;
            min_idx_ff   <= eval_idx_ff;
            min_stamp_ff <= rd_stamp;
         end
      end

      if (cmd.finish) begin
         if (op_ff == lfac_pkg::OP_INSERT) begin
            rsp_hit_ff          <= 1'b0;
            rsp_slot_ff         <= target;
            rsp_stored_value_ff <= '0;
            rsp_evicted_ff      <= !free_ff;
         end else begin
            rsp_hit_ff          <= found_ff;
            rsp_slot_ff         <= found_ff ? found_idx_ff : '0;
            rsp_stored_value_ff <= found_ff ?
               lfac_pkg::VALUE_PORT_BITS'(found_value_ff) : '0;
            rsp_evicted_ff      <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_stored_value = rsp_stored_value_ff;
   assign rsp_evicted      = rsp_evicted_ff;

endmodule

// File: rtl/lru_fully_associative_cache_core.sv
// top level of the fully associative key/value cache with lru replacement
//
// fully associative key/value store of ENTRIES entries with least recently
// used replacement by 32 bit timestamps. a beat is taken when start is high
// and busy is low; the result beat appears on the rsp_ ports for exactly
// one cycle with rsp_valid high and cannot be held off, so the receiver must
// take it then. every beat runs from acceptance to the result strobe through
// a scan of the entry ram at one entry per cycle through its single
// registered read port, an evaluation of the last entry read, a write of
// the chosen entry, if any, and the cycle in which the registered result is
// shown. the next beat may be started in the cycle the result is shown, but
// not before, as busy stays high until then. a lookup returns the lowest
// valid matching entry and restamps it; an insert fills the lowest free
// entry, or the oldest entry (lowest index on equal stamps) when the table
// is full, and never checks for duplicate keys. the use clock saturates
// at its maximum. key and value bits above KEY_BITS and VALUE_BITS are
// dropped. entry contents need no clearing after reset; of the entries
// only the per entry valid bits are reset.
module lru_fully_associative_cache_core #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [lfac_pkg::KEY_PORT_BITS-1:0]   req_key,
   input  logic [lfac_pkg::VALUE_PORT_BITS-1:0] req_value,
   // result channel
   output logic                                 rsp_valid,
   output logic                                 rsp_hit,
   output logic [$clog2(ENTRIES)-1:0]           rsp_slot,
   output logic [lfac_pkg::VALUE_PORT_BITS-1:0] rsp_stored_value,
   output logic                                 rsp_evicted
);

   lfac_pkg::ctl_cmd_type   cmd;
   lfac_pkg::dp_status_type status;

   // sequencing: idle, scan over all entries, finish
   lfac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .cmd   (cmd),
      .busy  (busy)
   );

   // entry ram, scan trackers, use clock and result registers
   lfac_dpath #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_hit         (rsp_hit),
      .rsp_slot        (rsp_slot),
      .rsp_stored_value(rsp_stored_value),
      .rsp_evicted     (rsp_evicted)
   );

`ifndef SYNTHESIS
   // an accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not make the block busy");

   // a result only follows a busy cycle and is shown once the block is free
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an operation");

   // a hit and an eviction never come together
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("result reports both hit and eviction");

   // a result strobe lasts one cycle only
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");
`endif

endmodule
